### hw/rtl/dfdp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the depth frame datagram parser
// no dependencies

package dfdp_pkg;

  // frame geometry and layout
  localparam int FrameWidth  = 40;
  localparam int FrameHeight = 30;
  localparam int CalWords    = 8;

  localparam int HdrFixed    = 25;
  localparam int PixelStride = 4;
  localparam int PixTotal    = FrameWidth * FrameHeight;
  localparam int CalBase     = HdrFixed;
  localparam int PixBase     = CalBase + 4 * CalWords;
  localparam int ExpectedLen = PixBase + PixelStride * PixTotal;

  localparam logic [31:0] CalBaseW     = 32'(CalBase);
  localparam logic [31:0] PixBaseW     = 32'(PixBase);
  localparam logic [31:0] ExpectedLenW = 32'(ExpectedLen);
  localparam logic [31:0] PixTotalW    = 32'(PixTotal);
  localparam logic [31:0] FrameWidthW  = 32'(FrameWidth);
  localparam logic [31:0] FrameHeightW = 32'(FrameHeight);

  localparam logic [12:0] PosMax = 13'h1fff;

  // timestamp arithmetic: ns / 1000 == (ns * DivMagic) >> 38 for any 32-bit ns
  localparam logic [19:0] UsecPerSec = 20'd1000000;
  localparam logic [28:0] DivMagic   = 29'h10624dd3;
  localparam int          DivShift   = 38;
  localparam int          NsProdW    = 61;
  localparam int          NsQuotW    = NsProdW - DivShift;
  localparam int          TsW        = 52;

  // queue depths
  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);

  typedef enum logic [1:0] {
    RK_PIXEL  = 2'd0,
    RK_CAL    = 2'd1,
    RK_STATUS = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_PARTIAL = 3'd2,
    ST_COUNT   = 3'd3,
    ST_DIMS    = 3'd4
  } frame_status_e;

  // one entry per byte that causes results
  typedef struct packed {
    logic          has_word;
    logic          word_is_cal;
    logic [10:0]   index;
    logic [31:0]   word;
    logic          has_status;
    frame_status_e status;
    logic [31:0]   seconds;
    logic [31:0]   nanos;
  } dfdp_cmd_t;

  typedef struct packed {
    result_kind_e    kind;
    logic [10:0]     pixel_index;
    logic [15:0]     depth;
    logic [7:0]      confidence;
    logic [2:0]      cal_index;
    logic [31:0]     cal_bits;
    logic [TsW-1:0]  timestamp;
    frame_status_e   status;
    logic            last;
  } dfdp_result_t;

endpackage

### hw/rtl/depth_frame_datagram_parser.sv
`timescale 1ns / 1ps
// result path: a byte that completes a pixel, calibration word or datagram passes its result
//   through the command queue, stage a, stage b and the result queue; the status follows a word result
// throughput: one byte per cycle while not full; results one per cycle while the result queue has room
// reset: asynchronous, clears all header fields, byte counter and both queues
// top level of the depth frame datagram parser; depends on dfdp_pkg, dfdp_front,
// dfdp_cmd_queue and dfdp_back

module depth_frame_datagram_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_datagram_i,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [10:0] pixel_index_o,
  output logic [15:0] depth_value_o,
  output logic [7:0]  confidence_value_o,
  output logic [2:0]  calibration_index_o,
  output logic [31:0] calibration_bits_o,
  output logic [51:0] timestamp_us_o,
  output logic [2:0]  frame_status_o,
  output logic        last_result_o
);

  // a byte transfer happens whenever push is high and the command queue has room
  logic                   accept;
  logic                   cmd_valid;
  dfdp_pkg::dfdp_cmd_t    cmd_in;
  dfdp_pkg::dfdp_cmd_t    cmd_head;
  logic                   cmd_empty;
  logic                   cmd_pop;
  dfdp_pkg::dfdp_result_t res;

  assign accept = push && !full;

  // front end: field assembly and per-byte classification, one byte a cycle while the command queue has room
  dfdp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .end_of_datagram_i (end_of_datagram_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd_in)
  );

  // decouples byte intake from result delivery; only bytes with results enter
  dfdp_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .head_o  (cmd_head)
  );

  // back end: splits a final byte into word and status results, computes the
  // microsecond timestamp in two registered steps, and holds finished results
  dfdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (res)
  );

  assign result_kind_o       = res.kind;
  assign pixel_index_o       = res.pixel_index;
  assign depth_value_o       = res.depth;
  assign confidence_value_o  = res.confidence;
  assign calibration_index_o = res.cal_index;
  assign calibration_bits_o  = res.cal_bits;
  assign timestamp_us_o      = res.timestamp;
  assign frame_status_o      = res.status;
  assign last_result_o       = res.last;

endmodule

### hw/rtl/dfdp_front.sv
`timescale 1ns / 1ps
// front end: header field assembly, byte classification, status checks
// depends on dfdp_pkg

module dfdp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_datagram_i,
  output logic              cmd_valid_o,
  output dfdp_pkg::dfdp_cmd_t cmd_o
);

  logic [12:0] pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [31:0] start_q, start_d;
  logic [15:0] count_q, count_d;
  logic [31:0] sec_q, sec_d;
  logic [31:0] ns_q, ns_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;

  logic [31:0] pos_w;
  logic [31:0] rel;
  logic [31:0] len;
  logic [1:0]  lane2;
  dfdp_pkg::dfdp_cmd_t cmd;

  assign pos_w = {19'b0, pos_q};
  assign lane2 = 2'(pos_q[1:0] + 2'd2);

  always_comb begin
    pos_d    = pos_q;
    word_d   = word_q;
    start_d  = start_q;
    count_d  = count_q;
    sec_d    = sec_q;
    ns_d     = ns_q;
    width_d  = width_q;
    height_d = height_q;
    rel      = '0;
    len      = pos_w + 32'd1;
    cmd      = '0;
    if (accept_i) begin
      word_d = {data_byte_i, word_q[31:8]};
      if (pos_q inside {[13'd4:13'd7]}) begin
        start_d[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (pos_q inside {[13'd8:13'd9]}) begin
        count_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      end else if (pos_q inside {[13'd10:13'd13]}) begin
        sec_d[{lane2, 3'b000} +: 8] = data_byte_i;
      end else if (pos_q inside {[13'd14:13'd17]}) begin
        ns_d[{lane2, 3'b000} +: 8] = data_byte_i;
      end else if (pos_q inside {[13'd18:13'd19]}) begin
        width_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      end else if (pos_q inside {[13'd20:13'd21]}) begin
        height_d[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      end else if (pos_w >= dfdp_pkg::CalBaseW && pos_w < dfdp_pkg::PixBaseW) begin
        rel = pos_w - dfdp_pkg::CalBaseW;
        if (rel[1:0] == 2'b11) begin
          cmd.has_word    = 1'b1;
          cmd.word_is_cal = 1'b1;
          cmd.index       = {8'b0, rel[4:2]};
          cmd.word        = word_d;
        end
      end else if (pos_w >= dfdp_pkg::PixBaseW && pos_w < dfdp_pkg::ExpectedLenW) begin
        rel = pos_w - dfdp_pkg::PixBaseW;
        if (rel[1:0] == 2'b11) begin
          cmd.has_word = 1'b1;
          cmd.index    = rel[12:2];
          cmd.word     = word_d;
        end
      end

      if (pos_q != dfdp_pkg::PosMax) begin
        pos_d = 13'(pos_q + 13'd1);
      end

      if (end_of_datagram_i) begin
        cmd.has_status = 1'b1;
        cmd.seconds    = sec_d;
        cmd.nanos      = ns_d;
        // checks in priority order
        if (len != dfdp_pkg::ExpectedLenW) begin
          cmd.status = dfdp_pkg::ST_LENGTH;
        end else if (start_d != 32'd0) begin
          cmd.status = dfdp_pkg::ST_PARTIAL;
        end else if ({16'b0, count_d} != dfdp_pkg::PixTotalW) begin
          cmd.status = dfdp_pkg::ST_COUNT;
        end else if ({16'b0, width_d} != dfdp_pkg::FrameWidthW ||
                     {16'b0, height_d} != dfdp_pkg::FrameHeightW) begin
          cmd.status = dfdp_pkg::ST_DIMS;
        end else begin
          cmd.status = dfdp_pkg::ST_OK;
        end
        // new datagram starts clean
        pos_d    = '0;
        word_d   = '0;
        start_d  = '0;
        count_d  = '0;
        sec_d    = '0;
        ns_d     = '0;
        width_d  = '0;
        height_d = '0;
      end
    end
  end

  assign cmd_valid_o = accept_i && (cmd.has_word || cmd.has_status);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      word_q   <= '0;
      start_q  <= '0;
      count_q  <= '0;
      sec_q    <= '0;
      ns_q     <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else begin
      pos_q    <= pos_d;
      word_q   <= word_d;
      start_q  <= start_d;
      count_q  <= count_d;
      sec_q    <= sec_d;
      ns_q     <= ns_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

endmodule

### hw/rtl/dfdp_cmd_queue.sv
`timescale 1ns / 1ps
// short command queue between front and back end
// depends on dfdp_pkg

module dfdp_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dfdp_pkg::dfdp_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dfdp_pkg::dfdp_cmd_t head_o
);

  dfdp_pkg::dfdp_cmd_t mem_q [dfdp_pkg::CmdDepth];

  logic [dfdp_pkg::CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [dfdp_pkg::CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [dfdp_pkg::CmdPtrW:0]   cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (dfdp_pkg::CmdPtrW+1)'(dfdp_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == dfdp_pkg::CmdPtrW'(dfdp_pkg::CmdDepth - 1)) ? '0
                 : dfdp_pkg::CmdPtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == dfdp_pkg::CmdPtrW'(dfdp_pkg::CmdDepth - 1)) ? '0
                 : dfdp_pkg::CmdPtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = (dfdp_pkg::CmdPtrW+1)'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = (dfdp_pkg::CmdPtrW+1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/dfdp_back.sv
`timescale 1ns / 1ps
// back end: splits commands into results, timestamp pipeline, result queue
// depends on dfdp_pkg

module dfdp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_empty_i,
  input  dfdp_pkg::dfdp_cmd_t    cmd_i,
  output logic                   cmd_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output dfdp_pkg::dfdp_result_t result_o
);

  // issue stage
  logic split_q, split_d;
  logic issue_valid;
  dfdp_pkg::dfdp_result_t issue_res;

  // stage a: operands
  logic                   a_valid_q;
  dfdp_pkg::dfdp_result_t a_res_q;
  logic [31:0]            a_sec_q, a_ns_q;

  // stage b: products
  logic                          b_valid_q;
  dfdp_pkg::dfdp_result_t        b_res_q;
  logic [dfdp_pkg::TsW-1:0]      b_sec_prod_q;
  logic [dfdp_pkg::NsQuotW-1:0]  b_ns_quot_q;

  logic [dfdp_pkg::TsW-1:0]      sec_prod;
  logic [dfdp_pkg::NsProdW-1:0]  ns_prod;
  logic [dfdp_pkg::TsW-1:0]      ts_sum;
  dfdp_pkg::dfdp_result_t        b_out;

  // result queue
  dfdp_pkg::dfdp_result_t        out_mem_q [dfdp_pkg::OutDepth];
  logic [dfdp_pkg::OutPtrW-1:0]  out_wr_q, out_rd_q;
  logic [dfdp_pkg::OutPtrW:0]    out_cnt_q;
  logic                          out_full, out_push, out_pop, move;

  assign out_full = (out_cnt_q == (dfdp_pkg::OutPtrW+1)'(dfdp_pkg::OutDepth));
  assign empty_o  = (out_cnt_q == '0);
  assign result_o = out_mem_q[out_rd_q];
  assign out_push = b_valid_q && !out_full;
  assign out_pop  = pop_i && !empty_o;
  // whole pipeline holds while its tail cannot drain
  assign move     = !(b_valid_q && out_full);

  always_comb begin
    issue_res   = '0;
    issue_valid = 1'b0;
    cmd_pop_o   = 1'b0;
    split_d     = split_q;
    if (!cmd_empty_i && move) begin
      issue_valid = 1'b1;
      if (cmd_i.has_word && !split_q) begin
        if (cmd_i.word_is_cal) begin
          issue_res.kind      = dfdp_pkg::RK_CAL;
          issue_res.cal_index = cmd_i.index[2:0];
          issue_res.cal_bits  = cmd_i.word;
        end else begin
          issue_res.kind        = dfdp_pkg::RK_PIXEL;
          issue_res.pixel_index = cmd_i.index;
          issue_res.depth       = cmd_i.word[15:0];
          issue_res.confidence  = cmd_i.word[23:16];
        end
        issue_res.last = !cmd_i.has_status;
        if (cmd_i.has_status) begin
          split_d = 1'b1;
        end else begin
          cmd_pop_o = 1'b1;
        end
      end else begin
        issue_res.kind   = dfdp_pkg::RK_STATUS;
        issue_res.status = cmd_i.status;
        issue_res.last   = 1'b1;
        cmd_pop_o        = 1'b1;
        split_d          = 1'b0;
      end
    end
  end

  assign sec_prod = dfdp_pkg::TsW'(a_sec_q) * dfdp_pkg::TsW'(dfdp_pkg::UsecPerSec);
  assign ns_prod  = dfdp_pkg::NsProdW'(a_ns_q) * dfdp_pkg::NsProdW'(dfdp_pkg::DivMagic);
  assign ts_sum   = dfdp_pkg::TsW'(b_sec_prod_q + dfdp_pkg::TsW'(b_ns_quot_q));

  always_comb begin
    b_out = b_res_q;
    if (b_res_q.kind == dfdp_pkg::RK_STATUS && b_res_q.status == dfdp_pkg::ST_OK) begin
      b_out.timestamp = ts_sum;
    end else begin
      b_out.timestamp = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      a_res_q      <= issue_res;
      a_sec_q      <= cmd_i.seconds;
      a_ns_q       <= cmd_i.nanos;
      b_res_q      <= a_res_q;
      b_sec_prod_q <= sec_prod;
      b_ns_quot_q  <= ns_prod[dfdp_pkg::NsProdW-1:dfdp_pkg::DivShift];
    end
    if (out_push) begin
      out_mem_q[out_wr_q] <= b_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q   <= 1'b0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      split_q <= split_d;
      if (move) begin
        a_valid_q <= issue_valid;
        b_valid_q <= a_valid_q;
      end
      if (out_push) begin
        out_wr_q <= (out_wr_q == dfdp_pkg::OutPtrW'(dfdp_pkg::OutDepth - 1)) ? '0
                    : dfdp_pkg::OutPtrW'(out_wr_q + 1'b1);
      end
      if (out_pop) begin
        out_rd_q <= (out_rd_q == dfdp_pkg::OutPtrW'(dfdp_pkg::OutDepth - 1)) ? '0
                    : dfdp_pkg::OutPtrW'(out_rd_q + 1'b1);
      end
      if (out_push && !out_pop) begin
        out_cnt_q <= (dfdp_pkg::OutPtrW+1)'(out_cnt_q + 1'b1);
      end else if (out_pop && !out_push) begin
        out_cnt_q <= (dfdp_pkg::OutPtrW+1)'(out_cnt_q - 1'b1);
      end
    end
  end

endmodule

### hw/rtl/dfdp_checker.sv
`timescale 1ns / 1ps
// port-level checks of the depth frame datagram parser, bound to the top level
// depends on dfdp_pkg and depth_frame_datagram_parser

module dfdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  result_kind_o,
  input logic [10:0] pixel_index_o,
  input logic [15:0] depth_value_o,
  input logic [2:0]  calibration_index_o,
  input logic [31:0] calibration_bits_o,
  input logic [51:0] timestamp_us_o,
  input logic [2:0]  frame_status_o,
  input logic        last_result_o
);

  // leaving reset, nothing is waiting and input is open
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("queues not clear after reset");

  // a status always closes the results of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_kind_o == 2'(dfdp_pkg::RK_STATUS) |-> last_result_o)
    else $error("status result without last flag");

  // word results carry no status and no timestamp
  a_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_kind_o != 2'(dfdp_pkg::RK_STATUS)
    |-> frame_status_o == 3'(dfdp_pkg::ST_OK) && timestamp_us_o == '0)
    else $error("word result with status fields");

  // a pixel result leaves calibration fields clear
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_kind_o == 2'(dfdp_pkg::RK_PIXEL)
    |-> calibration_index_o == '0 && calibration_bits_o == '0)
    else $error("pixel result with calibration fields");

  // a result not taken stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_kind_o) && $stable(pixel_index_o)
    && $stable(depth_value_o) && $stable(last_result_o))
    else $error("waiting result changed");

endmodule

bind depth_frame_datagram_parser dfdp_checker u_dfdp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .push                (push),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .result_kind_o       (result_kind_o),
  .pixel_index_o       (pixel_index_o),
  .depth_value_o       (depth_value_o),
  .calibration_index_o (calibration_index_o),
  .calibration_bits_o  (calibration_bits_o),
  .timestamp_us_o      (timestamp_us_o),
  .frame_status_o      (frame_status_o),
  .last_result_o       (last_result_o)
);
